### rtl/rcfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

  localparam int CHANNEL_BITS  = 11;
  localparam int CHANNEL_COUNT = 16;
  localparam int VALUE_BITS    = CHANNEL_BITS + 1;
  localparam int INDEX_BITS    = $clog2(CHANNEL_COUNT);
  localparam int POS_BITS      = 5;
  localparam int ACC_BITS      = CHANNEL_BITS + 7;
  localparam int CNT_BITS      = 5;

  localparam logic [POS_BITS-1:0] POS_FIRST_DATA = 5'd1;
  localparam logic [POS_BITS-1:0] POS_LAST_DATA  = 5'd22;
  localparam logic [POS_BITS-1:0] POS_FLAG       = 5'd23;
  localparam logic [POS_BITS-1:0] POS_TRIGGER    = 5'd24;
  localparam logic [POS_BITS-1:0] POS_IDLE       = 5'd25;

  localparam logic [INDEX_BITS-1:0] CH_STICK_DB   = 4'd2;
  localparam logic [INDEX_BITS-1:0] CH_STICK_TRIM = 4'd3;
  localparam logic [INDEX_BITS-1:0] CH_STICK_LAST = 4'd3;
  localparam logic [INDEX_BITS-1:0] CH_PASS_A     = 4'd8;
  localparam logic [INDEX_BITS-1:0] CH_PASS_B     = 4'd9;
  localparam logic [INDEX_BITS-1:0] CH_LAST       = 4'(CHANNEL_COUNT - 1);

  localparam logic [7:0]              START_BYTE_RST   = 8'd15;
  localparam logic [CHANNEL_BITS-1:0] STICK_OFFSET_RST = 11'd1024;
  localparam logic [3:0]              STICK4_TRIM_RST  = 4'd8;
  localparam logic [7:0]              DEADBAND_RST     = 8'd5;
  localparam logic [CHANNEL_BITS-1:0] JUMP_LIMIT_RST   = 11'd512;
  localparam logic [CHANNEL_BITS-1:0] SWITCH_LOW_RST   = 11'd352;
  localparam logic [CHANNEL_BITS-1:0] SWITCH_MID_RST   = 11'd1024;
  localparam logic [CHANNEL_BITS-1:0] SWITCH_HIGH_RST  = 11'd1695;

  typedef enum logic [2:0] {
    REG_START_BYTE   = 3'd0,
    REG_STICK_OFFSET = 3'd1,
    REG_STICK4_TRIM  = 3'd2,
    REG_DEADBAND     = 3'd3,
    REG_JUMP_LIMIT   = 3'd4,
    REG_SWITCH_LOW   = 3'd5,
    REG_SWITCH_MID   = 3'd6,
    REG_SWITCH_HIGH  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]              start_byte;
    logic [CHANNEL_BITS-1:0] stick_offset;
    logic [3:0]              stick4_trim;
    logic [7:0]              deadband;
    logic [CHANNEL_BITS-1:0] jump_limit;
    logic [CHANNEL_BITS-1:0] switch_low;
    logic [CHANNEL_BITS-1:0] switch_mid;
    logic [CHANNEL_BITS-1:0] switch_high;
  } cfg_t;

  typedef struct packed {
    logic       go;
    logic [7:0] flag;
  } frame_ctl_t;

endpackage

`default_nettype wire

### rtl/rcfd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

interface rcfd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [rcfd_pkg::INDEX_BITS-1:0]       channel_index;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] channel_value;
  logic [7:0]                            flag_byte;
  logic                                  frame_end;

  modport source(output valid, output channel_index, output channel_value,
                 output flag_byte, output frame_end, input ready);
  modport sink(input valid, input channel_index, input channel_value,
               input flag_byte, input frame_end, output ready);
endinterface

`default_nettype wire

### rtl/rcfd_unpack.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfd_unpack (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                beat,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                frame_start,
  input  wire logic [7:0]                          start_byte,
  input  wire logic [rcfd_pkg::INDEX_BITS-1:0]     rd_idx,
  output logic [rcfd_pkg::CHANNEL_BITS-1:0]        rd_raw,
  output rcfd_pkg::frame_ctl_t                     ctl
);

  logic [rcfd_pkg::POS_BITS-1:0]     pos;
  logic                              accepted;
  logic [rcfd_pkg::ACC_BITS-1:0]     acc;
  logic [rcfd_pkg::CNT_BITS-1:0]     cnt;
  logic [rcfd_pkg::INDEX_BITS-1:0]   wr_idx;
  logic [7:0]                        flag;
  logic                              go;
  logic [rcfd_pkg::CHANNEL_BITS-1:0] raw_store [rcfd_pkg::CHANNEL_COUNT];

  logic [rcfd_pkg::POS_BITS-1:0]   p;
  logic                            acc_ok;
  logic [rcfd_pkg::ACC_BITS-1:0]   a0;
  logic [rcfd_pkg::ACC_BITS-1:0]   sum;
  logic [rcfd_pkg::CNT_BITS-1:0]   c0;
  logic [rcfd_pkg::CNT_BITS-1:0]   c1;
  logic [rcfd_pkg::INDEX_BITS-1:0] w0;
  logic                            is_data;
  logic                            full;

  always_comb begin
    p       = frame_start ? '0 : pos;
    acc_ok  = frame_start ? (data_byte == start_byte) : accepted;
    is_data = (p >= rcfd_pkg::POS_FIRST_DATA) && (p <= rcfd_pkg::POS_LAST_DATA);
    a0      = (p == rcfd_pkg::POS_FIRST_DATA) ? '0 : acc;
    c0      = (p == rcfd_pkg::POS_FIRST_DATA) ? '0 : cnt;
    w0      = (p == rcfd_pkg::POS_FIRST_DATA) ? '0 : wr_idx;
    sum     = a0 | ({{(rcfd_pkg::ACC_BITS-8){1'b0}}, data_byte} << c0);
    c1      = c0 + 5'd8;
    full    = (c1 >= 5'(rcfd_pkg::CHANNEL_BITS));
  end

  // bit accumulator: one channel completes per byte at most
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      accepted <= 1'b0;
      go       <= 1'b0;
    end else begin
      go <= 1'b0;
      if (beat) begin
        if (p < rcfd_pkg::POS_TRIGGER) begin
          pos      <= p + 5'd1;
          accepted <= acc_ok;
        end else if (p != rcfd_pkg::POS_TRIGGER) begin
          pos <= rcfd_pkg::POS_IDLE;
        end else begin
          pos <= rcfd_pkg::POS_IDLE;
          if (acc_ok) begin
            go       <= 1'b1;
            accepted <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat && is_data) begin
      if (full) begin
        raw_store[w0] <= sum[rcfd_pkg::CHANNEL_BITS-1:0];
        acc           <= sum >> rcfd_pkg::CHANNEL_BITS;
        cnt           <= c1 - 5'(rcfd_pkg::CHANNEL_BITS);
        wr_idx        <= w0 + 4'd1;
      end else begin
        acc    <= sum;
        cnt    <= c1;
        wr_idx <= w0;
      end
    end
    if (beat && p == rcfd_pkg::POS_FLAG) begin
      flag <= data_byte;
    end
  end

  assign rd_raw   = raw_store[rd_idx];
  assign ctl.go   = go;
  assign ctl.flag = flag;

endmodule

`default_nettype wire

### rtl/rcfd_chan_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfd_chan_unit (
  input  wire logic [rcfd_pkg::INDEX_BITS-1:0]          ch,
  input  wire logic [rcfd_pkg::CHANNEL_BITS-1:0]        raw,
  input  wire logic signed [rcfd_pkg::VALUE_BITS-1:0]   prev,
  input  wire rcfd_pkg::cfg_t                           cfg,
  output logic signed [rcfd_pkg::VALUE_BITS-1:0]        value
);

  logic signed [rcfd_pkg::VALUE_BITS:0]   v0;
  logic signed [rcfd_pkg::VALUE_BITS:0]   trim;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] v1;
  logic signed [rcfd_pkg::VALUE_BITS:0]   d;
  logic [rcfd_pkg::VALUE_BITS:0]          dabs;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] v2;
  logic [rcfd_pkg::VALUE_BITS:0]          mag;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] stick;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] raw_v;
  logic                                   hit;

  always_comb begin
    raw_v = $signed({1'b0, raw});
    trim  = (ch == rcfd_pkg::CH_STICK_TRIM) ? $signed({9'd0, cfg.stick4_trim}) : '0;
    v0    = $signed({2'b00, raw}) - $signed({2'b00, cfg.stick_offset}) - trim;
    // saturate at the bottom of the 12-bit range
    v1    = (v0 < -13'sd2048) ? -12'sd2048 : v0[rcfd_pkg::VALUE_BITS-1:0];
    d     = {v1[rcfd_pkg::VALUE_BITS-1], v1} - {prev[rcfd_pkg::VALUE_BITS-1], prev};
    dabs  = d[rcfd_pkg::VALUE_BITS] ? 13'(-d) : 13'(d);
    v2    = (dabs >= {2'b00, cfg.jump_limit}) ? prev : v1;
    mag   = v2[rcfd_pkg::VALUE_BITS-1] ? 13'(-{v2[rcfd_pkg::VALUE_BITS-1], v2})
                                       : 13'({v2[rcfd_pkg::VALUE_BITS-1], v2});
    stick = ((ch >= rcfd_pkg::CH_STICK_DB) && (mag < {5'd0, cfg.deadband})) ? '0 : v2;
    hit   = (raw == cfg.switch_low) || (raw == cfg.switch_mid) || (raw == cfg.switch_high);
    if (ch <= rcfd_pkg::CH_STICK_LAST) begin
      value = stick;
    end else if (ch inside {rcfd_pkg::CH_PASS_A, rcfd_pkg::CH_PASS_B}) begin
      value = raw_v;
    end else begin
      value = hit ? raw_v : prev;
    end
  end

endmodule

`default_nettype wire

### rtl/rcfd_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module rcfd_emit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rcfd_pkg::frame_ctl_t              ctl,
  input  wire logic [rcfd_pkg::CHANNEL_BITS-1:0] rd_raw,
  input  wire rcfd_pkg::cfg_t                    cfg,
  output logic [rcfd_pkg::INDEX_BITS-1:0]        rd_idx,
  output logic                                   busy,
  rcfd_out_if.source                             res
);

  logic                                   out_valid;
  logic [rcfd_pkg::INDEX_BITS-1:0]        out_idx;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] out_value;
  logic [7:0]                             out_flag;
  logic                                   out_last;
  logic [rcfd_pkg::INDEX_BITS-1:0]        ch;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] prev [rcfd_pkg::CHANNEL_COUNT];

  logic                                   advance;
  logic signed [rcfd_pkg::VALUE_BITS-1:0] value;

  rcfd_chan_unit u_unit (
    .ch    (ch),
    .raw   (rd_raw),
    .prev  (prev[ch]),
    .cfg   (cfg),
    .value (value)
  );

  assign advance = busy && (!out_valid || res.ready);

  // one channel per cycle through the shared unit while the result side is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ch        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < rcfd_pkg::CHANNEL_COUNT; i++) begin
        prev[i] <= '0;
      end
    end else begin
      if (advance) begin
        prev[ch]  <= value;
        out_valid <= 1'b1;
        out_idx   <= ch;
        out_value <= value;
        out_flag  <= ctl.flag;
        out_last  <= (ch == rcfd_pkg::CH_LAST);
        if (ch == rcfd_pkg::CH_LAST) begin
          busy <= 1'b0;
        end else begin
          ch <= ch + 4'd1;
        end
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.go) begin
        busy <= 1'b1;
        ch   <= '0;
      end
    end
  end

  assign rd_idx            = ch;
  assign res.valid         = out_valid;
  assign res.channel_index = out_idx;
  assign res.channel_value = out_value;
  assign res.flag_byte     = out_flag;
  assign res.frame_end     = out_last;

  a_go_idle: assert property (@(posedge clk) disable iff (rst) ctl.go |-> !busy)
    else $error("frame start while channels still in flight");
  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    ctl.go |=> busy && ch == '0)
    else $error("sequencer did not start at the first channel");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    advance && ch == rcfd_pkg::CH_LAST |=> !busy && out_valid && out_last)
    else $error("sequencer did not finish after the last channel");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_idx == rcfd_pkg::CH_LAST)))
    else $error("last flag out of step with channel index");

endmodule

`default_nettype wire

### rtl/rc_receiver_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel      dir  width  content
// frame_bytes  in   9      data_byte, frame_start
// channels     out  25     channel_index, channel_value, flag_byte, frame_end
// cfg_*        in   3+11   register index, write data
//
// 25 byte beats make a frame
// the trigger byte starts 16 result beats, one channel per cycle through the
// shared channel unit while channels is not stalled; frame_bytes.ready stays low
// while the sequencer is busy; a stall on channels freezes the channel sequencer
// synchronous reset restores register defaults and clears previous values

module rc_receiver_frame_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [rcfd_pkg::CHANNEL_BITS-1:0] cfg_data,
  rcfd_in_if.sink                                frame_bytes,
  rcfd_out_if.source                             channels
);

  rcfd_pkg::cfg_t                    cfg;
  rcfd_pkg::frame_ctl_t              ctl;
  logic [rcfd_pkg::INDEX_BITS-1:0]   rd_idx;
  logic [rcfd_pkg::CHANNEL_BITS-1:0] rd_raw;
  logic                              busy;
  logic                              beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte   <= rcfd_pkg::START_BYTE_RST;
      cfg.stick_offset <= rcfd_pkg::STICK_OFFSET_RST;
      cfg.stick4_trim  <= rcfd_pkg::STICK4_TRIM_RST;
      cfg.deadband     <= rcfd_pkg::DEADBAND_RST;
      cfg.jump_limit   <= rcfd_pkg::JUMP_LIMIT_RST;
      cfg.switch_low   <= rcfd_pkg::SWITCH_LOW_RST;
      cfg.switch_mid   <= rcfd_pkg::SWITCH_MID_RST;
      cfg.switch_high  <= rcfd_pkg::SWITCH_HIGH_RST;
    end else if (cfg_we) begin
      case (rcfd_pkg::cfg_reg_t'(cfg_index))
        rcfd_pkg::REG_START_BYTE:   cfg.start_byte   <= cfg_data[7:0];
        rcfd_pkg::REG_STICK_OFFSET: cfg.stick_offset <= cfg_data;
        rcfd_pkg::REG_STICK4_TRIM:  cfg.stick4_trim  <= cfg_data[3:0];
        rcfd_pkg::REG_DEADBAND:     cfg.deadband     <= cfg_data[7:0];
        rcfd_pkg::REG_JUMP_LIMIT:   cfg.jump_limit   <= cfg_data;
        rcfd_pkg::REG_SWITCH_LOW:   cfg.switch_low   <= cfg_data;
        rcfd_pkg::REG_SWITCH_MID:   cfg.switch_mid   <= cfg_data;
        rcfd_pkg::REG_SWITCH_HIGH:  cfg.switch_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign frame_bytes.ready = !busy;
  assign beat              = frame_bytes.valid && !busy;

  rcfd_unpack u_unpack (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .data_byte   (frame_bytes.data_byte),
    .frame_start (frame_bytes.frame_start),
    .start_byte  (cfg.start_byte),
    .rd_idx      (rd_idx),
    .rd_raw      (rd_raw),
    .ctl         (ctl)
  );

  rcfd_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd_raw (rd_raw),
    .cfg    (cfg),
    .rd_idx (rd_idx),
    .busy   (busy),
    .res    (channels)
  );

endmodule

`default_nettype wire

### tb/sv/rcfd_channel_checker.sv
`timescale 1ns / 1ps

module rcfd_channel_checker
  import rcfd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [CHANNEL_BITS-1:0]      cfg_data,
  input  logic                         byte_valid,
  input  logic                         byte_ready,
  input  logic [7:0]                   byte_data,
  input  logic                         byte_start,
  input  logic                         beat_valid,
  input  logic                         beat_ready,
  input  logic [INDEX_BITS-1:0]        beat_index,
  input  logic signed [VALUE_BITS-1:0] beat_value,
  input  logic [7:0]                   beat_flag,
  input  logic                         beat_last,
  output int                           mismatches,
  output int                           pending,
  output int                           frames_decoded,
  output int                           beats_checked
);

  typedef struct packed {
    logic [INDEX_BITS-1:0]        index;
    logic signed [VALUE_BITS-1:0] value;
    logic [7:0]                   flag;
    logic                         last;
  } channel_beat_t;

  cfg_t                         regs;
  logic [7:0]                   frame_data [0:POS_TRIGGER-1];
  logic [POS_BITS-1:0]          byte_pos;
  logic                         frame_open;
  logic signed [VALUE_BITS-1:0] held_value [CHANNEL_COUNT];
  channel_beat_t                expected_channels [$];

  function automatic logic signed [VALUE_BITS-1:0] protect_channel(int ch, int raw);
    int prev;
    int v;
    int delta;
    prev = held_value[ch];
    if (ch <= int'(CH_STICK_LAST)) begin
      v = raw - int'(regs.stick_offset);
      if (ch == int'(CH_STICK_TRIM)) v = v - int'(regs.stick4_trim);
      if (v < -2048) v = -2048;
      delta = (v > prev) ? v - prev : prev - v;
      if (delta >= int'(regs.jump_limit)) v = prev;
      if (ch >= int'(CH_STICK_DB) && ((v < 0) ? -v : v) < int'(regs.deadband)) v = 0;
    end else if (ch == int'(CH_PASS_A) || ch == int'(CH_PASS_B)) begin
      v = raw;
    end else if (raw == int'(regs.switch_low) || raw == int'(regs.switch_mid) ||
                 raw == int'(regs.switch_high)) begin
      v = raw;
    end else begin
      v = prev;
    end
    return v[VALUE_BITS-1:0];
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic s);
    logic [8*22-1:0]              bit_stream;
    logic signed [VALUE_BITS-1:0] v;
    if (s) begin
      byte_pos   = '0;
      frame_open = (b == regs.start_byte);
    end
    if (byte_pos < POS_TRIGGER) begin
      frame_data[byte_pos] = b;
      byte_pos = byte_pos + 1'b1;
    end else if (byte_pos != POS_TRIGGER || !frame_open) begin
      byte_pos = POS_IDLE;
    end else begin
      byte_pos   = POS_IDLE;
      frame_open = 1'b0;
      for (int i = POS_FIRST_DATA; i <= POS_LAST_DATA; i++) begin
        bit_stream[8*(i-1) +: 8] = frame_data[i];
      end
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
        v = protect_channel(ch, int'(bit_stream[CHANNEL_BITS*ch +: CHANNEL_BITS]));
        held_value[ch] = v;
        expected_channels.push_back(channel_beat_t'{index: ch[INDEX_BITS-1:0], value: v,
                                                    flag: frame_data[POS_FLAG],
                                                    last: (ch == int'(CH_LAST))});
      end
      frames_decoded++;
    end
  endtask

  task automatic compare_beat();
    channel_beat_t want;
    if (expected_channels.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected channel beat: idx %0d value %0d flag %02h last %0b",
                 beat_index, beat_value, beat_flag, beat_last);
      mismatches++;
    end else begin
      want = expected_channels.pop_front();
      beats_checked++;
      if (beat_index !== want.index || beat_value !== want.value ||
          beat_flag !== want.flag || beat_last !== want.last) begin
        if (mismatches < 10)
          $display("channel beat wrong: expected idx %0d value %0d flag %02h last %0b",
                   want.index, want.value, want.flag, want.last,
                   ", got idx %0d value %0d flag %02h last %0b",
                   beat_index, beat_value, beat_flag, beat_last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs = '{start_byte: START_BYTE_RST, stick_offset: STICK_OFFSET_RST,
               stick4_trim: STICK4_TRIM_RST, deadband: DEADBAND_RST,
               jump_limit: JUMP_LIMIT_RST, switch_low: SWITCH_LOW_RST,
               switch_mid: SWITCH_MID_RST, switch_high: SWITCH_HIGH_RST};
      byte_pos   = '0;
      frame_open = 1'b0;
      foreach (held_value[k]) held_value[k] = '0;
      expected_channels.delete();
      mismatches     = 0;
      frames_decoded = 0;
      beats_checked  = 0;
    end else begin
      if (beat_valid && beat_ready) compare_beat();
      if (byte_valid && byte_ready) take_byte(byte_data, byte_start);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_BYTE:   regs.start_byte   = cfg_data[7:0];
          REG_STICK_OFFSET: regs.stick_offset = cfg_data;
          REG_STICK4_TRIM:  regs.stick4_trim  = cfg_data[3:0];
          REG_DEADBAND:     regs.deadband     = cfg_data[7:0];
          REG_JUMP_LIMIT:   regs.jump_limit   = cfg_data;
          REG_SWITCH_LOW:   regs.switch_low   = cfg_data;
          REG_SWITCH_MID:   regs.switch_mid   = cfg_data;
          REG_SWITCH_HIGH:  regs.switch_high  = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_channels.size();
  end

endmodule

### tb/sv/rc_receiver_frame_decoder_test.sv
`timescale 1ns / 1ps

module rc_receiver_frame_decoder_test;
  import rcfd_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_BYTES   = 12;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [2:0]              cfg_index;
  logic [CHANNEL_BITS-1:0] cfg_data;

  int mismatches;
  int pending;
  int frames_decoded;
  int beats_checked;

  logic [CHANNEL_BITS-1:0] chan_raw [CHANNEL_COUNT];
  int                      stick_raw [4];
  logic [7:0]              cur_start;
  logic [CHANNEL_BITS-1:0] cur_offset;
  logic [CHANNEL_BITS-1:0] cur_low;
  logic [CHANNEL_BITS-1:0] cur_mid;
  logic [CHANNEL_BITS-1:0] cur_high;
  int                      bytes_sent;
  int                      settings_used;
  bit                      no_gaps;
  bit                      steady_sink;

  rcfd_in_if  frame_bytes ();
  rcfd_out_if channels ();

  rc_receiver_frame_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame_bytes (frame_bytes),
    .channels    (channels)
  );

  rcfd_channel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .byte_valid     (frame_bytes.valid),
    .byte_ready     (frame_bytes.ready),
    .byte_data      (frame_bytes.data_byte),
    .byte_start     (frame_bytes.frame_start),
    .beat_valid     (channels.valid),
    .beat_ready     (channels.ready),
    .beat_index     (channels.channel_index),
    .beat_value     (channels.channel_value),
    .beat_flag      (channels.flag_byte),
    .beat_last      (channels.frame_end),
    .mismatches     (mismatches),
    .pending        (pending),
    .frames_decoded (frames_decoded),
    .beats_checked  (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stalls per beat, with stretches of none
  initial begin
    int stall;
    int beats;
    channels.ready = 1'b0;
    beats = 0;
    steady_sink = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (beats % 24 == 0) steady_sink = ($urandom_range(0, 3) == 0);
      stall = steady_sink ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        channels.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      channels.ready = 1'b1;
      @(posedge clk);
      while (!channels.valid) @(posedge clk);
      beats++;
      @(negedge clk);
    end
  end

  function automatic logic [CHANNEL_BITS-1:0] clamp_raw(int v);
    if (v < 0) return '0;
    if (v > 2047) return 11'h7FF;
    return v[CHANNEL_BITS-1:0];
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] pick_value(int lo, int hi);
    case ($urandom_range(0, 3))
      0:       return lo[CHANNEL_BITS-1:0];
      1:       return hi[CHANNEL_BITS-1:0];
      default: return CHANNEL_BITS'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      frame_bytes.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_bytes.valid       = 1'b1;
    frame_bytes.data_byte   = b;
    frame_bytes.frame_start = s;
    @(posedge clk);
    while (!frame_bytes.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] first, input logic [7:0] flag,
                            input logic [7:0] trigger);
    logic [8*22-1:0] bit_stream;
    for (int k = 0; k < CHANNEL_COUNT; k++) begin
      bit_stream[CHANNEL_BITS*k +: CHANNEL_BITS] = chan_raw[k];
    end
    send_byte(first, 1'b1);
    for (int i = 0; i < 22; i++) send_byte(bit_stream[8*i +: 8], 1'b0);
    send_byte(flag, 1'b0);
    send_byte(trigger, 1'b0);
  endtask

  task automatic settle();
    frame_bytes.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CHANNEL_BITS-1:0] d);
    cfg_we    = 1'b1;
    cfg_index = r;
    cfg_data  = d;
    case (r)
      REG_START_BYTE:   cur_start  = d[7:0];
      REG_STICK_OFFSET: cur_offset = d;
      REG_SWITCH_LOW:   cur_low    = d;
      REG_SWITCH_MID:   cur_mid    = d;
      REG_SWITCH_HIGH:  cur_high   = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_config();
    write_reg(REG_START_BYTE, pick_value(0, 255));
    write_reg(REG_STICK_OFFSET, pick_value(0, 2047));
    write_reg(REG_STICK4_TRIM, pick_value(0, 15));
    write_reg(REG_DEADBAND, pick_value(0, 255));
    write_reg(REG_JUMP_LIMIT, pick_value(1, 2047));
    write_reg(REG_SWITCH_LOW, pick_value(0, 2047));
    write_reg(REG_SWITCH_MID, pick_value(0, 2047));
    write_reg(REG_SWITCH_HIGH, pick_value(0, 2047));
  endtask

  task automatic random_frame();
    int         pick;
    int         step;
    logic [7:0] first;
    for (int k = 0; k <= CH_STICK_LAST; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        step = int'($urandom_range(0, 120)) - 60;
        stick_raw[k] = stick_raw[k] + step;
      end else if (pick < 8) begin
        stick_raw[k] = $urandom_range(0, 2047);
      end else if (pick == 8) begin
        stick_raw[k] = int'(cur_offset) + int'($urandom_range(0, 16)) - 8;
      end else begin
        stick_raw[k] = $urandom_range(0, 1) ? 2047 : 0;
      end
      chan_raw[k] = clamp_raw(stick_raw[k]);
      stick_raw[k] = int'(chan_raw[k]);
    end
    for (int k = CH_STICK_LAST + 1; k < CHANNEL_COUNT; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: chan_raw[k] = cur_low;
        3, 4:    chan_raw[k] = cur_mid;
        5, 6:    chan_raw[k] = cur_high;
        default: chan_raw[k] = CHANNEL_BITS'($urandom);
      endcase
    end
    chan_raw[CH_PASS_A] = CHANNEL_BITS'($urandom);
    chan_raw[CH_PASS_B] = CHANNEL_BITS'($urandom);
    first = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_start;
    send_frame(first, 8'($urandom), 8'($urandom));
  endtask

  // stray bytes, cut-off frames and restarts
  task automatic line_noise();
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      1: begin
        send_byte(cur_start, 1'b1);
        repeat ($urandom_range(1, 23)) send_byte(8'($urandom), 1'b0);
      end
      default: begin
        send_byte(8'($urandom), 1'b1);
        repeat ($urandom_range(0, 26)) send_byte(8'($urandom), 1'b0);
      end
    endcase
  endtask

  initial begin
    int phase_start;
    int waited;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_START_BYTE;
    cfg_data                = '0;
    frame_bytes.valid       = 1'b0;
    frame_bytes.data_byte   = '0;
    frame_bytes.frame_start = 1'b0;
    bytes_sent              = 0;
    settings_used           = 1;
    no_gaps                 = 1'b0;
    cur_start               = START_BYTE_RST;
    cur_offset              = STICK_OFFSET_RST;
    cur_low                 = SWITCH_LOW_RST;
    cur_mid                 = SWITCH_MID_RST;
    cur_high                = SWITCH_HIGH_RST;
    foreach (stick_raw[k]) stick_raw[k] = int'(STICK_OFFSET_RST);
    foreach (chan_raw[k]) chan_raw[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // bytes with no start, then a frame with the wrong start byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    foreach (chan_raw[k]) chan_raw[k] = 11'd1000;
    send_frame(8'hF0, 8'h3C, 8'h00);

    // sticks near center, one below it and two in the deadband, switches on legal positions
    chan_raw[0] = 11'd1027;
    chan_raw[1] = 11'd724;
    chan_raw[2] = 11'd1026;
    chan_raw[3] = 11'd1036;
    for (int k = CH_STICK_LAST + 1; k < CHANNEL_COUNT; k++) begin
      chan_raw[k] = (k % 3 == 0) ? cur_low : (k % 3 == 1) ? cur_mid : cur_high;
    end
    chan_raw[CH_PASS_A] = 11'd0;
    chan_raw[CH_PASS_B] = 11'h7FF;
    send_frame(cur_start, 8'h00, 8'hFF);
    foreach (chan_raw[k]) chan_raw[k] = 11'd0;
    send_frame(cur_start, 8'hFF, 8'h00);
    foreach (chan_raw[k]) chan_raw[k] = 11'h7FF;
    send_frame(cur_start, 8'hA5, 8'h5A);

    // restart in mid frame, then a byte past the trigger
    send_byte(cur_start, 1'b1);
    repeat (10) send_byte(8'h33, 1'b0);
    foreach (chan_raw[k]) chan_raw[k] = CHANNEL_BITS'($urandom_range(900, 1150));
    send_frame(cur_start, 8'h0F, 8'hF0);
    send_byte(8'h77, 1'b0);
    settle();

    // extreme registers, stick four driven into underflow
    write_reg(REG_START_BYTE, 11'd0);
    write_reg(REG_STICK_OFFSET, 11'd2047);
    write_reg(REG_STICK4_TRIM, 11'd15);
    write_reg(REG_DEADBAND, 11'd255);
    write_reg(REG_JUMP_LIMIT, 11'd2047);
    write_reg(REG_SWITCH_LOW, 11'd0);
    write_reg(REG_SWITCH_MID, 11'd2047);
    write_reg(REG_SWITCH_HIGH, 11'd1000);
    settings_used++;
    foreach (chan_raw[k]) chan_raw[k] = 11'd1000;
    send_frame(8'h00, 8'h81, 8'h18);
    foreach (chan_raw[k]) chan_raw[k] = 11'd0;
    chan_raw[CH_PASS_B] = 11'h7FF;
    send_frame(8'h00, 8'h7E, 8'hE7);
    settle();

    // zero jump limit: sticks never move
    write_reg(REG_START_BYTE, 11'd255);
    write_reg(REG_STICK_OFFSET, 11'd0);
    write_reg(REG_STICK4_TRIM, 11'd0);
    write_reg(REG_DEADBAND, 11'd0);
    write_reg(REG_JUMP_LIMIT, 11'd0);
    write_reg(REG_SWITCH_LOW, 11'd1);
    write_reg(REG_SWITCH_MID, 11'd1024);
    write_reg(REG_SWITCH_HIGH, 11'd2046);
    settings_used++;
    foreach (chan_raw[k]) chan_raw[k] = CHANNEL_BITS'($urandom);
    send_frame(8'hFF, 8'($urandom), 8'($urandom));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        write_reg(REG_START_BYTE, 11'(START_BYTE_RST));
        write_reg(REG_STICK_OFFSET, STICK_OFFSET_RST);
        write_reg(REG_STICK4_TRIM, 11'(STICK4_TRIM_RST));
        write_reg(REG_DEADBAND, 11'(DEADBAND_RST));
        write_reg(REG_JUMP_LIMIT, JUMP_LIMIT_RST);
        write_reg(REG_SWITCH_LOW, SWITCH_LOW_RST);
        write_reg(REG_SWITCH_MID, SWITCH_MID_RST);
        write_reg(REG_SWITCH_HIGH, SWITCH_HIGH_RST);
      end else begin
        random_config();
      end
      settings_used++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        no_gaps = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0) line_noise();
        else random_frame();
        if ($urandom_range(0, 9) == 0) settle();
      end
      settle();
    end

    frame_bytes.valid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 4000) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d frame bytes under %0d register settings, %0d frames decoded",
             bytes_sent, settings_used, frames_decoded);
    $display("%0d channel beats compared, %0d wrong, %0d still outstanding",
             beats_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
